>>> rtl/dpsm_pkg.sv
// Shared types and constants of the dual period speed meter.
`default_nettype none

package dpsm_pkg;

    // Fixed field widths of the interface.
    localparam int unsigned TPS_W       = 20;
    localparam int unsigned STALL_W     = 24;
    localparam int unsigned RATE_W      = 28;
    localparam int unsigned CFG_IDX_W   = 2;
    localparam int unsigned CFG_DATA_W  = 24;
    localparam int unsigned S_TDATA_W   = 8;
    localparam int unsigned M_TDATA_W   = 64;

    // Reset values of the configuration registers.
    localparam logic [TPS_W-1:0]   TPS_RESET   = TPS_W'(100000);
    localparam logic [STALL_W-1:0] STALL_RESET = STALL_W'(25000);

    // Saturated rate, also reported for a zero period.
    localparam logic [RATE_W-1:0]  RATE_MAX    = '1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_TPS   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_STALL = CFG_IDX_W'(1);

    // Bit positions of the result transfer.
    localparam int unsigned OUT_SPEED_A_LSB = 0;
    localparam int unsigned OUT_SPEED_B_LSB = RATE_W;
    localparam int unsigned OUT_STALL_A_BIT = 2 * RATE_W;
    localparam int unsigned OUT_STALL_B_BIT = 2 * RATE_W + 1;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_NEXT,
        ST_DIV,
        ST_EMIT
    } state_t;

endpackage

`default_nettype wire

>>> rtl/dual_period_speed_meter.sv
// Top level of the dual period speed meter: counters, sequencer and ports.
//
// Usage: each transfer on the s_ channel carries a timebase tick and one
// rising-edge flag per channel. The tick advances both period counters
// (saturating); an edge snapshots its counter, clears it, and starts a
// rate computation rate = (ticks_per_second << FRAC_BITS) / period.
// Every input transfer yields exactly one m_ transfer with both speeds and
// both stall flags. A channel whose counter is at or above stall_ticks
// reads speed zero and stalled one.
// Timing: the block takes one item at a time. An item without edges passes
// through ST_NEXT and ST_EMIT to the result register; the next item is
// taken once the block is back in ST_IDLE. Each edge with a nonzero period
// runs the shared restoring divider, one quotient bit per cycle; an edge
// with a zero period skips the divider and reads the saturated rate.
// The cfg_ channel is always ready; the user must write it only while
// idle. The block itself does not enforce this.
// Reset: synchronous, active low; counters start at 25000 (clipped to the
// counter range), rates at zero, registers at their default values.
// Stall: a result waits in the output register until m_tready; the block
// then holds off the next input only when it has a new result to load.
`default_nettype none

module dual_period_speed_meter
    import dpsm_pkg::*;
#(
    parameter int unsigned COUNT_WIDTH = 24,
    parameter int unsigned FRAC_BITS   = 8
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // Input transfer.
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // s_tdata: tick [0], edge_a [1], edge_b [2], zero fill [7:3]
    input  wire logic [S_TDATA_W-1:0]  s_tdata,
    // Result transfer.
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // m_tdata: speed_a [27:0], speed_b [55:28], stalled_a [56],
    //          stalled_b [57], zero fill [63:58]
    output logic [M_TDATA_W-1:0]       m_tdata,
    // Configuration write channel.
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int unsigned DVD_W = TPS_W + FRAC_BITS;
    localparam int unsigned QX_W  = (DVD_W > RATE_W) ? DVD_W : RATE_W;
    localparam int unsigned CMP_W = (COUNT_WIDTH > STALL_W) ? COUNT_WIDTH : STALL_W;
    localparam longint unsigned CNT_MAX_L = (64'd1 << COUNT_WIDTH) - 64'd1;
    localparam longint unsigned STALL_RESET_L = 64'(STALL_RESET);
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;
    localparam logic [COUNT_WIDTH-1:0] CNT_RESET =
        COUNT_WIDTH'((STALL_RESET_L > CNT_MAX_L) ? CNT_MAX_L : STALL_RESET_L);

    state_t state_reg, state_next;

    logic [TPS_W-1:0]       tps_reg;
    logic [STALL_W-1:0]     stall_reg;
    logic [COUNT_WIDTH-1:0] cnt_a_reg, cnt_a_next;
    logic [COUNT_WIDTH-1:0] cnt_b_reg, cnt_b_next;
    logic [COUNT_WIDTH-1:0] per_a_reg, per_a_next;
    logic [COUNT_WIDTH-1:0] per_b_reg, per_b_next;
    logic                   pend_a_reg, pend_a_next;
    logic                   pend_b_reg, pend_b_next;
    logic                   sel_b_reg, sel_b_next;
    logic [RATE_W-1:0]      rate_a_reg, rate_a_next;
    logic [RATE_W-1:0]      rate_b_reg, rate_b_next;
    logic                   m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0]   m_data_reg, m_data_next;

    logic                   accept;
    logic                   tick, edge_a, edge_b;
    logic [COUNT_WIDTH-1:0] cnt_a_tick, cnt_b_tick;
    logic                   div_start;
    logic [COUNT_WIDTH-1:0] div_divisor;
    logic                   div_done;
    logic [DVD_W-1:0]       div_quo;
    logic [QX_W-1:0]        quo_ext;
    logic [RATE_W-1:0]      quo_sat;
    logic                   stalled_a, stalled_b;
    logic                   out_free;

    assign accept    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_free  = !m_valid_reg || m_tready;

    assign tick   = s_tdata[0];
    assign edge_a = s_tdata[1];
    assign edge_b = s_tdata[2];

    // Saturating tick increment of both period counters.
    assign cnt_a_tick = (tick && (cnt_a_reg != CNT_MAX)) ? cnt_a_reg + COUNT_WIDTH'(1) : cnt_a_reg;
    assign cnt_b_tick = (tick && (cnt_b_reg != CNT_MAX)) ? cnt_b_reg + COUNT_WIDTH'(1) : cnt_b_reg;

    // Quotient clipped to the rate range.
    assign quo_ext = QX_W'(div_quo);
    assign quo_sat = (quo_ext > QX_W'(RATE_MAX)) ? RATE_MAX : quo_ext[RATE_W-1:0];

    // Stall test against the limit, both sides widened to a common width.
    assign stalled_a = CMP_W'(cnt_a_reg) >= CMP_W'(stall_reg);
    assign stalled_b = CMP_W'(cnt_b_reg) >= CMP_W'(stall_reg);

    assign div_divisor = sel_b_next ? per_b_reg : per_a_reg;

    // Sequencer: take an item, run the pending divisions, load the result.
    always_comb begin
        state_next   = state_reg;
        cnt_a_next   = cnt_a_reg;
        cnt_b_next   = cnt_b_reg;
        per_a_next   = per_a_reg;
        per_b_next   = per_b_reg;
        pend_a_next  = pend_a_reg;
        pend_b_next  = pend_b_reg;
        sel_b_next   = sel_b_reg;
        rate_a_next  = rate_a_reg;
        rate_b_next  = rate_b_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        div_start    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cnt_a_next  = edge_a ? '0 : cnt_a_tick;
                    cnt_b_next  = edge_b ? '0 : cnt_b_tick;
                    per_a_next  = cnt_a_tick;
                    per_b_next  = cnt_b_tick;
                    pend_a_next = edge_a;
                    pend_b_next = edge_b;
                    state_next  = ST_NEXT;
                end
            end
            ST_NEXT: begin
                if (pend_a_reg) begin
                    sel_b_next = 1'b0;
                    if (per_a_reg == '0) begin
                        rate_a_next = RATE_MAX;
                        pend_a_next = 1'b0;
                    end else begin
                        div_start  = 1'b1;
                        state_next = ST_DIV;
                    end
                end else if (pend_b_reg) begin
                    sel_b_next = 1'b1;
                    if (per_b_reg == '0) begin
                        rate_b_next = RATE_MAX;
                        pend_b_next = 1'b0;
                    end else begin
                        div_start  = 1'b1;
                        state_next = ST_DIV;
                    end
                end else begin
                    state_next = ST_EMIT;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    if (sel_b_reg) begin
                        rate_b_next = quo_sat;
                        pend_b_next = 1'b0;
                    end else begin
                        rate_a_next = quo_sat;
                        pend_a_next = 1'b0;
                    end
                    state_next = ST_NEXT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = '0;
                    m_data_next[OUT_SPEED_A_LSB +: RATE_W] = stalled_a ? '0 : rate_a_reg;
                    m_data_next[OUT_SPEED_B_LSB +: RATE_W] = stalled_b ? '0 : rate_b_reg;
                    m_data_next[OUT_STALL_A_BIT] = stalled_a;
                    m_data_next[OUT_STALL_B_BIT] = stalled_b;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // State, counters, rates and configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            tps_reg     <= TPS_RESET;
            stall_reg   <= STALL_RESET;
            cnt_a_reg   <= CNT_RESET;
            cnt_b_reg   <= CNT_RESET;
            pend_a_reg  <= 1'b0;
            pend_b_reg  <= 1'b0;
            sel_b_reg   <= 1'b0;
            rate_a_reg  <= '0;
            rate_b_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_a_reg   <= cnt_a_next;
            cnt_b_reg   <= cnt_b_next;
            pend_a_reg  <= pend_a_next;
            pend_b_reg  <= pend_b_next;
            sel_b_reg   <= sel_b_next;
            rate_a_reg  <= rate_a_next;
            rate_b_reg  <= rate_b_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    REG_TPS:   tps_reg   <= cfg_data[TPS_W-1:0];
                    REG_STALL: stall_reg <= cfg_data[STALL_W-1:0];
                    default: ;
                endcase
            end
        end
        per_a_reg  <= per_a_next;
        per_b_reg  <= per_b_next;
        m_data_reg <= m_data_next;
    end

    // Shared divider for both channels.
    dpsm_div #(
        .DVD_W (DVD_W),
        .DVS_W (COUNT_WIDTH)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (DVD_W'(tps_reg) << FRAC_BITS),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

`default_nettype wire

>>> rtl/dpsm_div.sv
// Restoring divider that produces one quotient bit per cycle.
`default_nettype none

module dpsm_div
    import dpsm_pkg::*;
#(
    parameter int unsigned DVD_W = 28,
    parameter int unsigned DVS_W = 24
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [DVD_W-1:0] dividend,
    input  wire logic [DVS_W-1:0] divisor,
    output logic                  done,
    output logic [DVD_W-1:0]      quotient
);

    localparam int unsigned CNT_W = $clog2(DVD_W + 1);

    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [DVD_W-1:0] quo_reg, quo_next;
    logic [DVS_W-1:0] dvs_reg, dvs_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    logic [DVS_W:0]   trial;
    logic             fits;

    // One restoring step: shift in the next dividend bit and try a subtract.
    assign trial = {rem_reg, quo_reg[DVD_W-1]};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
            cnt_next  = CNT_W'(DVD_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (fits) begin
                rem_next = DVS_W'(trial - {1'b0, dvs_reg});
            end else begin
                rem_next = trial[DVS_W-1:0];
            end
            quo_next = {quo_reg[DVD_W-2:0], fits};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state is reset; the datapath registers are not.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

>>> rtl/dpsm_check.sv
// Port-level checks of the dual period speed meter, bound to the top level.
`default_nettype none

module dpsm_check
    import dpsm_pkg::*;
(
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 s_tvalid,
    input wire logic                 s_tready,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [M_TDATA_W-1:0] m_tdata
);

    // A stalled result waits unchanged.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // A stalled channel always reports zero speed.
    a_stall_a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[OUT_STALL_A_BIT] |-> m_tdata[OUT_SPEED_A_LSB +: RATE_W] == '0)
        else $error("channel A stalled with nonzero speed");

    a_stall_b_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[OUT_STALL_B_BIT] |-> m_tdata[OUT_SPEED_B_LSB +: RATE_W] == '0)
        else $error("channel B stalled with nonzero speed");

    // The block works on one item at a time.
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while an item is in progress");

endmodule

bind dual_period_speed_meter dpsm_check u_dpsm_check (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

>>> sim/testbench.sv
// Self-checking testbench for the dual period speed meter.
`default_nettype none

module testbench;
    import dpsm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Build parameters of the block under test.
    localparam int unsigned COUNT_W = 24;
    localparam int unsigned FRAC_W  = 8;
    localparam logic [COUNT_W-1:0] COUNT_FULL = '1;

    // Register indexes that decode to nothing.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = CFG_IDX_W'(3);

    // Run control.
    localparam int unsigned RESET_CYCLES  = 12;
    localparam int unsigned HOLD_CYCLES   = 400;
    localparam int unsigned SETTLE_CYCLES = 100;
    localparam int unsigned IDLE_LIMIT    = 5000;
    localparam int unsigned RANDOM_PHASES = 6;
    localparam int unsigned PHASE_ITEMS   = 315;

    // One result transfer split into its fields.
    typedef struct packed {
        logic [RATE_W-1:0] speed_a;
        logic [RATE_W-1:0] speed_b;
        logic              stalled_a;
        logic              stalled_b;
    } speed_report_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // Shadow copy of the meter: registers, period counters and held rates.
    logic [TPS_W-1:0]      tps_shadow   = TPS_RESET;
    logic [STALL_W-1:0]    stall_shadow = STALL_RESET;
    logic [COUNT_W-1:0]    period_a     = COUNT_W'(STALL_RESET);
    logic [COUNT_W-1:0]    period_b     = COUNT_W'(STALL_RESET);
    logic [RATE_W-1:0]     held_rate_a  = '0;
    logic [RATE_W-1:0]     held_rate_b  = '0;

    speed_report_t pending_reports[$];

    int unsigned mismatches      = 0;
    int unsigned items_accepted  = 0;
    int unsigned reports_checked = 0;
    int unsigned stall_reports   = 0;
    int unsigned saturated_rates = 0;
    int unsigned settings_used   = 0;
    int unsigned idle_cycles     = 0;
    int unsigned burst_left      = 0;
    bit          steady_feed     = 1'b0;
    bit          hold_request    = 1'b0;

    dual_period_speed_meter #(
        .COUNT_WIDTH(COUNT_W),
        .FRAC_BITS  (FRAC_W)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    // Clock generation.
    initial begin
        forever #5 aclk = ~aclk;
    end

    // Rate for a captured period, saturated at the top of the output range.
    function automatic logic [RATE_W-1:0] rate_for_period(input logic [COUNT_W-1:0] period);
        logic [63:0] dividend;
        logic [63:0] quotient;
        if (period == '0) begin
            return RATE_MAX;
        end
        dividend = 64'(tps_shadow) << FRAC_W;
        quotient = dividend / 64'(period);
        return (quotient > 64'(RATE_MAX)) ? RATE_MAX : quotient[RATE_W-1:0];
    endfunction

    // Advances the shadow meter by one item and returns the report it yields.
    // The tick is applied before the edges, and the stall test sees the result.
    function automatic speed_report_t step_meter(input logic tick, input logic pulse_a,
                                                 input logic pulse_b);
        speed_report_t report;
        if (tick) begin
            if (period_a != COUNT_FULL) period_a = period_a + 1'b1;
            if (period_b != COUNT_FULL) period_b = period_b + 1'b1;
        end
        if (pulse_a) begin
            held_rate_a = rate_for_period(period_a);
            period_a    = '0;
        end
        if (pulse_b) begin
            held_rate_b = rate_for_period(period_b);
            period_b    = '0;
        end
        report.stalled_a = (32'(period_a) >= 32'(stall_shadow));
        report.stalled_b = (32'(period_b) >= 32'(stall_shadow));
        report.speed_a   = report.stalled_a ? '0 : held_rate_a;
        report.speed_b   = report.stalled_b ? '0 : held_rate_b;
        return report;
    endfunction

    // Sends one item, in bursts with random gaps unless steady_feed is set, then records its report.
    task automatic send_item(input logic tick, input logic pulse_a, input logic pulse_b);
        int unsigned gap;
        gap = 0;
        if (!steady_feed) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 16);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            end
            burst_left--;
        end
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b00000, pulse_b, pulse_a, tick};
        do @(posedge aclk); while (!s_tready);
        pending_reports.push_back(step_meter(tick, pulse_a, pulse_b));
        items_accepted++;
    endtask

    // Writes one configuration register and mirrors it in the shadow.
    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        case (index)
            REG_TPS: begin
                tps_shadow = value[TPS_W-1:0];
            end
            REG_STALL: begin
                stall_shadow = value[STALL_W-1:0];
            end
            default: begin
            end
        endcase
        settings_used++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Stops feeding and waits until every recorded report has come back.
    task automatic drain_reports();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge aclk);
    endtask

    // Item with a random tick and pulses whose spacing follows the stall limit.
    task automatic send_random_item(input int unsigned span);
        if ($urandom_range(0, 9) == 0) begin
            send_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
        end else begin
            send_item($urandom_range(0, 3) != 0, $urandom_range(0, span - 1) == 0,
                      $urandom_range(0, span) == 0);
        end
    endtask

    // Default registers: both channels start stalled at the reset count.
    task automatic check_reset_state();
        send_item(1'b0, 1'b0, 1'b0);
        send_item(1'b1, 1'b0, 1'b0);
        send_item(1'b0, 1'b1, 1'b0);
        // A second pulse without a tick gives a zero period on channel A.
        send_item(1'b0, 1'b1, 1'b1);
        send_item(1'b1, 1'b0, 1'b1);
        drain_reports();
    endtask

    // Largest and zero dividend, shortest periods and the saturated rate.
    task automatic check_divider_extremes();
        write_register(REG_TPS, '1);
        send_item(1'b1, 1'b0, 1'b0);
        send_item(1'b0, 1'b1, 1'b1);
        send_item(1'b1, 1'b0, 1'b0);
        send_item(1'b1, 1'b1, 1'b0);
        send_item(1'b0, 1'b0, 1'b1);
        drain_reports();
        write_register(REG_TPS, {4'hF, 20'h00000});
        send_item(1'b1, 1'b1, 1'b0);
        send_item(1'b1, 1'b0, 1'b1);
        send_item(1'b0, 1'b1, 1'b1);
        drain_reports();
    endtask

    // A zero limit always reads stalled; the largest limit reads stalled only for a saturated counter.
    task automatic check_stall_limits();
        write_register(REG_TPS, CFG_DATA_W'(TPS_RESET));
        write_register(REG_STALL, '0);
        send_item(1'b0, 1'b0, 1'b0);
        send_item(1'b1, 1'b1, 1'b1);
        drain_reports();
        write_register(REG_STALL, '1);
        send_item(1'b1, 1'b0, 1'b0);
        send_item(1'b1, 1'b1, 1'b0);
        drain_reports();
    endtask

    // Writes to undecoded indexes must leave both registers alone.
    task automatic check_unknown_register();
        write_register(REG_SPARE_LO, CFG_DATA_W'(1));
        write_register(REG_SPARE_HI, CFG_DATA_W'(1));
        send_item(1'b1, 1'b0, 1'b1);
        send_item(1'b1, 1'b0, 1'b0);
        send_item(1'b1, 1'b1, 1'b0);
        drain_reports();
    endtask

    // Random traffic over several register settings.
    task automatic check_random_traffic();
        logic [CFG_DATA_W-1:0] tps_word;
        logic [CFG_DATA_W-1:0] stall_word;
        int unsigned           span;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            tps_word = CFG_DATA_W'($urandom);
            case ($urandom_range(0, 5))
                0: tps_word[TPS_W-1:0] = '0;
                1: tps_word[TPS_W-1:0] = '1;
                2: tps_word[TPS_W-1:0] = TPS_W'(1);
                default: begin
                end
            endcase
            case ($urandom_range(0, 6))
                0: stall_word = '0;
                1: stall_word = '1;
                2: stall_word = CFG_DATA_W'($urandom_range(1000, 30000));
                default: stall_word = CFG_DATA_W'($urandom_range(1, 48));
            endcase
            write_register(REG_TPS, tps_word);
            write_register(REG_STALL, stall_word);
            span = (stall_word >= 2 && stall_word <= 48) ? stall_word + 2
                                                         : $urandom_range(2, 40);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_random_item(span);
            end
            drain_reports();
        end
    endtask

    // The receiver holds off while the sender keeps offering items.
    task automatic check_output_backpressure();
        write_register(REG_STALL, CFG_DATA_W'(20));
        steady_feed  = 1'b1;
        hold_request = 1'b1;
        for (int n = 0; n < 40; n++) begin
            send_random_item(12);
        end
        steady_feed = 1'b0;
        drain_reports();
    endtask

    // Receiver: random stalls, long ready stretches, and the requested hold.
    initial begin : receiver
        int unsigned ready_run;
        int unsigned stall_left;
        ready_run  = 0;
        stall_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge aclk);
                hold_request = 1'b0;
            end else if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                m_tready <= 1'b1;
                if (ready_run > 0) begin
                    ready_run--;
                end else begin
                    ready_run  = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                             : $urandom_range(0, 12);
                    stall_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
        end
    end

    // Compare each result transfer with the oldest recorded report.
    always @(posedge aclk) begin : result_check
        speed_report_t seen;
        speed_report_t want;
        if (aresetn && m_tvalid && m_tready) begin
            seen.speed_a   = m_tdata[OUT_SPEED_A_LSB +: RATE_W];
            seen.speed_b   = m_tdata[OUT_SPEED_B_LSB +: RATE_W];
            seen.stalled_a = m_tdata[OUT_STALL_A_BIT];
            seen.stalled_b = m_tdata[OUT_STALL_B_BIT];
            if (pending_reports.size() == 0) begin
                $error("result transfer with no report pending: m_tdata=%h", m_tdata);
                mismatches++;
            end else begin
                want = pending_reports.pop_front();
                reports_checked++;
                if (want.stalled_a || want.stalled_b) stall_reports++;
                if (want.speed_a == RATE_MAX || want.speed_b == RATE_MAX) saturated_rates++;
                if (seen.speed_a !== want.speed_a) begin
                    $error("speed_a: expected %0d, got %0d", want.speed_a, seen.speed_a);
                    mismatches++;
                end
                if (seen.speed_b !== want.speed_b) begin
                    $error("speed_b: expected %0d, got %0d", want.speed_b, seen.speed_b);
                    mismatches++;
                end
                if (seen.stalled_a !== want.stalled_a) begin
                    $error("stalled_a: expected %0b, got %0b", want.stalled_a, seen.stalled_a);
                    mismatches++;
                end
                if (seen.stalled_b !== want.stalled_b) begin
                    $error("stalled_b: expected %0b, got %0b", want.stalled_b, seen.stalled_b);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Watchdog expired with %0d reports pending.", pending_reports.size());
            $display("RESULT: ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Test sequence.
    initial begin
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;
        check_reset_state();
        check_divider_extremes();
        check_stall_limits();
        check_unknown_register();
        check_random_traffic();
        check_output_backpressure();
        drain_reports();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (pending_reports.size() != 0) begin
            $error("%0d reports never arrived", pending_reports.size());
            mismatches++;
        end
        $display("Checked %0d reports from %0d input items over %0d register writes.",
                 reports_checked, items_accepted, settings_used);
        $display("Reports with a stalled channel: %0d, with a saturated rate: %0d.",
                 stall_reports, saturated_rates);
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire

>>> sim.f
rtl/dpsm_pkg.sv
rtl/dpsm_div.sv
rtl/dual_period_speed_meter.sv
rtl/dpsm_check.sv
sim/testbench.sv
